// File: src/sclx_pkg.sv
// Shared types and character/code constants for the command-line lexer.
package sclx_pkg;

    // Input transfer: one byte of the line, or the end-of-line marker
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } lex_in_t;

    // Result transfer
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_char;
        logic [2:0] tok_class;
        logic [1:0] status;
        logic [5:0] token_count;
        logic       last;
    } lex_res_t;

    // Result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOK_END   = 2'd1;
    localparam logic [1:0] KIND_LINE_DONE = 2'd2;

    // Token types
    localparam logic [2:0] TT_WORD   = 3'd0;
    localparam logic [2:0] TT_OUT    = 3'd1;
    localparam logic [2:0] TT_APPEND = 3'd2;
    localparam logic [2:0] TT_IN     = 3'd3;
    localparam logic [2:0] TT_PIPE   = 3'd4;
    localparam logic [2:0] TT_OR     = 3'd5;

    // Line status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

endpackage

// File: src/shell_command_line_lexer_unit.sv
// Command-line lexer top level: byte-wise tokeniser with a four-entry result queue.
//
// Takes one command line a byte per transfer, closed by a transfer with line_end set,
// and splits it into tokens: spaces separate, single quotes are literal, double quotes
// are literal except that a backslash before " \ $ or ` gives that character, an
// unquoted backslash takes the next byte literally, and > >> < | || stand as tokens of
// their own. Each token is delivered as its characters followed by a token-end result
// whose type comes from the finished text (so a quoted '>' is still type out); each line
// closes with a line-done result carrying the status (ok, token too long, unmatched
// quote) and the token count. A token may hold TOKEN_CHARS-1 characters; one more ends
// the line's useful work with status too long. After TOKEN_SLOTS-1 tokens the rest of
// the line is dropped silently. A byte is lexed in the cycle it is accepted and its
// results land in the queue at that edge, so the first of them is offered in the next
// cycle: one input transfer per cycle is taken whenever the queue has two free entries,
// and results leave one per cycle while m_ready is high. A byte produces zero, one or
// two results, so with m_ready high the sustained rate is one byte per cycle while bytes
// average at most one result each, and is set by the single result port otherwise (as
// for a run of < characters, each of which closes the previous token and opens its own).
// The last flag marks the final result caused by each input transfer.
module shell_command_line_lexer_unit
    import sclx_pkg::*;
#(
    parameter int TOKEN_CHARS = 256,
    parameter int TOKEN_SLOTS = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  lex_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output lex_res_t m_data
);

    localparam int CCW = $clog2(TOKEN_CHARS);
    localparam int TDW = $clog2(TOKEN_SLOTS);
    localparam logic [CCW-1:0] CC_MAX = CCW'(TOKEN_CHARS - 1);
    localparam logic [TDW-1:0] TD_MAX = TDW'(TOKEN_SLOTS - 1);

    // Lexer modes
    localparam logic [3:0] M_BETWEEN = 4'd0;
    localparam logic [3:0] M_WORD    = 4'd1;
    localparam logic [3:0] M_SQ      = 4'd2;
    localparam logic [3:0] M_DQ      = 4'd3;
    localparam logic [3:0] M_ESC     = 4'd4;
    localparam logic [3:0] M_DQESC   = 4'd5;
    localparam logic [3:0] M_GT      = 4'd6;
    localparam logic [3:0] M_PIPE    = 4'd7;
    localparam logic [3:0] M_OPDONE  = 4'd8;
    localparam logic [3:0] M_IGNORE  = 4'd9;

    typedef struct packed {
        logic [3:0]     mode;
        logic [1:0]     err;
        logic [CCW-1:0] cc;     // characters in the current token
        logic [7:0]     a;      // first character of the token
        logic [7:0]     b;      // second character of the token
        logic [TDW-1:0] td;     // tokens finished in this line
    } lex_st_t;

    // State plus the results produced so far by the current byte
    typedef struct packed {
        lex_st_t          st;
        logic [1:0]       n;
        lex_res_t [1:0]   res;
    } lex_work_t;

    // ------------------------------------------------------------------
    // Step helpers
    // ------------------------------------------------------------------
    function automatic logic [5:0] count6(input logic [TDW-1:0] td);
        logic [TDW+5:0] ext;
        ext = {6'b0, td};
        return ext[5:0];
    endfunction

    function automatic lex_work_t f_emit(input lex_work_t w, input logic [1:0] kind,
                                         input logic [7:0] c, input logic [2:0] tt,
                                         input logic [1:0] status);
        lex_work_t r;
        lex_res_t  e;
        r = w;
        e.kind        = kind;
        e.out_char    = c;
        e.tok_class   = tt;
        e.status      = status;
        e.token_count = count6(w.st.td);
        e.last        = 1'b0;
        if (w.n < 2'd2) begin
            r.res[w.n[0]] = e;
            r.n = w.n + 2'd1;
        end
        return r;
    endfunction

    // Append a character; on overflow flag the line and drop the rest of it
    function automatic lex_work_t f_add(input lex_work_t w, input logic [7:0] c);
        lex_work_t r;
        r = w;
        if (w.st.cc < CC_MAX) begin
            if (w.st.cc == CCW'(0)) begin
                r.st.a = c;
            end
            if (w.st.cc == CCW'(1)) begin
                r.st.b = c;
            end
            r.st.cc = w.st.cc + CCW'(1);
            r = f_emit(r, KIND_CHAR, c, TT_WORD, ST_OK);
        end else begin
            r.st.err  = ST_TOO_LONG;
            r.st.mode = M_IGNORE;
        end
        return r;
    endfunction

    function automatic logic [2:0] f_type(input lex_st_t s);
        logic [2:0] t;
        t = TT_WORD;
        if (s.cc == CCW'(1)) begin
            if (s.a == CH_GT) begin
                t = TT_OUT;
            end else if (s.a == CH_LT) begin
                t = TT_IN;
            end else if (s.a == CH_PIPE) begin
                t = TT_PIPE;
            end
        end else if (s.cc == CCW'(2)) begin
            if (s.a == CH_GT && s.b == CH_GT) begin
                t = TT_APPEND;
            end else if (s.a == CH_PIPE && s.b == CH_PIPE) begin
                t = TT_OR;
            end
        end
        return t;
    endfunction

    // Close the current token; at the token limit the line goes quiet
    function automatic lex_work_t f_finish(input lex_work_t w);
        lex_work_t  r;
        logic [2:0] t;
        r = w;
        t = f_type(w.st);
        r.st.td = w.st.td + TDW'(1);
        r = f_emit(r, KIND_TOK_END, 8'd0, t, ST_OK);
        r.st.cc   = '0;
        r.st.a    = '0;
        r.st.b    = '0;
        r.st.mode = M_BETWEEN;
        if (r.st.td >= TD_MAX) begin
            r.st.mode = M_IGNORE;
        end
        return r;
    endfunction

    function automatic lex_work_t f_word(input lex_work_t w, input logic [7:0] c);
        lex_work_t r;
        r = w;
        case (c)
            CH_SPACE: begin
                r = f_finish(r);
            end
            CH_GT, CH_LT, CH_PIPE: begin
                if (r.st.cc != CCW'(0)) begin
                    r = f_finish(r);
                end
                if (r.st.mode != M_IGNORE) begin
                    r = f_add(r, c);
                    if (r.st.mode != M_IGNORE) begin
                        r.st.mode = (c == CH_GT)   ? M_GT :
                                    (c == CH_PIPE) ? M_PIPE : M_OPDONE;
                    end
                end
            end
            CH_SQUOTE: r.st.mode = M_SQ;
            CH_DQUOTE: r.st.mode = M_DQ;
            CH_BSLASH: r.st.mode = M_ESC;
            default:   r = f_add(r, c);
        endcase
        return r;
    endfunction

    function automatic lex_work_t f_between(input lex_work_t w, input logic [7:0] c);
        lex_work_t r;
        r = w;
        if (c != CH_SPACE) begin
            r.st.mode = M_WORD;
            r = f_word(r, c);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // State and result queue
    // ------------------------------------------------------------------
    lex_st_t    st_reg;
    lex_work_t  w_next;
    lex_res_t   q_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       s_fire, m_fire;
    logic [1:0] push_n;
    logic [7:0] c;
    logic [7:0] op_ch;

    // Room for the worst case of two results from one byte
    assign s_ready = (count_reg <= 3'd2);
    assign s_fire  = s_valid & s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_fire  = m_valid & m_ready;
    assign m_data  = q_reg[rd_ptr_reg];
    assign c       = s_data.ch;
    assign op_ch   = (st_reg.mode == M_GT) ? CH_GT : CH_PIPE;

    // One byte of lexing
    always_comb begin
        w_next     = '0;
        w_next.st  = st_reg;
        if (s_data.line_end) begin
            case (st_reg.mode)
                M_SQ, M_DQ, M_DQESC: begin
                    w_next.st.err = ST_UNMATCHED;
                end
                M_WORD, M_ESC, M_GT, M_PIPE, M_OPDONE: begin
                    w_next = f_finish(w_next);
                end
                default: ;
            endcase
            w_next = f_emit(w_next, KIND_LINE_DONE, 8'd0, TT_WORD, w_next.st.err);
            w_next.st      = '0;
            w_next.st.mode = M_BETWEEN;
        end else begin
            case (st_reg.mode)
                M_BETWEEN: w_next = f_between(w_next, c);
                M_WORD:    w_next = f_word(w_next, c);
                M_SQ: begin
                    if (c == CH_SQUOTE) begin
                        w_next.st.mode = M_WORD;
                    end else begin
                        w_next = f_add(w_next, c);
                    end
                end
                M_DQ: begin
                    if (c == CH_DQUOTE) begin
                        w_next.st.mode = M_WORD;
                    end else if (c == CH_BSLASH) begin
                        w_next.st.mode = M_DQESC;
                    end else begin
                        w_next = f_add(w_next, c);
                    end
                end
                M_ESC: begin
                    w_next.st.mode = M_WORD;
                    w_next = f_add(w_next, c);
                end
                M_DQESC: begin
                    w_next.st.mode = M_DQ;
                    if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR ||
                        c == CH_BTICK) begin
                        w_next = f_add(w_next, c);
                    end else begin
                        // backslash kept literally, then the byte itself
                        w_next = f_add(w_next, CH_BSLASH);
                        if (w_next.st.mode != M_IGNORE) begin
                            w_next = f_add(w_next, c);
                        end
                    end
                end
                M_GT, M_PIPE: begin
                    if (c == op_ch) begin
                        w_next = f_add(w_next, c);
                        if (w_next.st.mode != M_IGNORE) begin
                            w_next = f_finish(w_next);
                        end
                    end else begin
                        w_next = f_finish(w_next);
                        if (w_next.st.mode != M_IGNORE) begin
                            w_next = f_between(w_next, c);
                        end
                    end
                end
                M_OPDONE: begin
                    w_next = f_finish(w_next);
                    if (w_next.st.mode != M_IGNORE) begin
                        w_next = f_between(w_next, c);
                    end
                end
                default: ;
            endcase
        end
        if (w_next.n == 2'd2) begin
            w_next.res[1].last = 1'b1;
        end else if (w_next.n == 2'd1) begin
            w_next.res[0].last = 1'b1;
        end
    end

    assign push_n      = s_fire ? w_next.n : 2'd0;
    assign wr_ptr_next = wr_ptr_reg + push_n;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, m_fire};
    assign count_next  = count_reg + {1'b0, push_n} - {2'b0, m_fire};

    // All-zero state is the between-tokens mode with empty counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end else begin
            if (s_fire) begin
                st_reg <= w_next.st;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_reg[wr_ptr_reg] <= w_next.res[0];
        end
        if (push_n == 2'd2) begin
            q_reg[wr_ptr_reg + 2'd1] <= w_next.res[1];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overfilled");

    a_line_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.line_end) |=>
            (st_reg.mode == M_BETWEEN && st_reg.cc == '0 && st_reg.td == '0 &&
             st_reg.err == ST_OK))
        else $error("state not cleared after end of line");

    a_token_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.td == TD_MAX) |-> (st_reg.mode == M_IGNORE))
        else $error("token limit reached without ignoring the line");

    a_line_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_LINE_DONE) |-> m_data.last)
        else $error("line done not marked last");

endmodule

// File: sim/tb_shell_command_line_lexer_unit.sv
// Self-checking testbench for the command-line lexer: directed table, random lines, predictor.
`timescale 1ns / 1ps

module tb_shell_command_line_lexer_unit;
    import sclx_pkg::*;

    localparam int TOKEN_CHARS  = 256;
    localparam int TOKEN_SLOTS  = 64;
    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRILL_ROWS   = 13;

    // Lexer modes, mirrored inside the predictor
    typedef enum logic [3:0] {
        LM_BETWEEN, LM_WORD, LM_SQ, LM_DQ, LM_ESC, LM_DQESC,
        LM_GT, LM_PIPE, LM_OPDONE, LM_IGNORE
    } lex_mode_t;

    // Directed row: text, then fill repeated reps times, then end of line if eol.
    // When typed is set, want replaces the prediction for the row's final transfer.
    typedef struct {
        string      text;
        logic [7:0] fill;
        int         reps;
        bit         eol;
        bit         typed;
        lex_res_t   want;
    } drill_row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    lex_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    lex_res_t m_data;

    // Predictor state
    lex_mode_t   lx_mode;
    int unsigned lx_chars;
    logic [7:0]  lx_first;
    logic [7:0]  lx_second;
    int unsigned lx_tokens;
    logic [1:0]  lx_err;
    lex_res_t    step_res[$];

    // Expected results in order, and bookkeeping
    lex_res_t    want_q[$];
    logic [7:0]  line_q[$];
    drill_row_t  drill_tab [DRILL_ROWS];
    int unsigned mismatches;
    int unsigned cyc_count;
    int unsigned sent_items;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold;

    shell_command_line_lexer_unit #(
        .TOKEN_CHARS(TOKEN_CHARS),
        .TOKEN_SLOTS(TOKEN_SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void lex_restart();
        lx_mode   = LM_BETWEEN;
        lx_chars  = 0;
        lx_first  = 8'h00;
        lx_second = 8'h00;
        lx_tokens = 0;
        lx_err    = ST_OK;
    endfunction

    function automatic void put_res(logic [1:0] kind, logic [7:0] c, logic [2:0] tt,
                                    logic [1:0] st);
        lex_res_t r;
        r.kind        = kind;
        r.out_char    = c;
        r.tok_class   = tt;
        r.status      = st;
        r.token_count = 6'(lx_tokens);
        r.last        = 1'b0;
        step_res.push_back(r);
    endfunction

    // Appends a character to the token; overflow kills the rest of the line
    function automatic bit take_char(logic [7:0] c);
        if (lx_chars < TOKEN_CHARS - 1) begin
            if (lx_chars == 0)
                lx_first = c;
            else if (lx_chars == 1)
                lx_second = c;
            lx_chars++;
            put_res(KIND_CHAR, c, TT_WORD, ST_OK);
            return 1'b1;
        end
        lx_err  = ST_TOO_LONG;
        lx_mode = LM_IGNORE;
        return 1'b0;
    endfunction

    // Type follows the finished text, quoted or not
    function automatic logic [2:0] text_type();
        if (lx_chars == 1) begin
            if (lx_first == CH_GT)
                return TT_OUT;
            if (lx_first == CH_LT)
                return TT_IN;
            if (lx_first == CH_PIPE)
                return TT_PIPE;
        end else if (lx_chars == 2) begin
            if (lx_first == CH_GT && lx_second == CH_GT)
                return TT_APPEND;
            if (lx_first == CH_PIPE && lx_second == CH_PIPE)
                return TT_OR;
        end
        return TT_WORD;
    endfunction

    // Returns 0 once the token limit is reached and the line goes quiet
    function automatic bit close_token();
        logic [2:0] tt;
        tt = text_type();
        lx_tokens++;
        put_res(KIND_TOK_END, 8'h00, tt, ST_OK);
        lx_chars  = 0;
        lx_first  = 8'h00;
        lx_second = 8'h00;
        lx_mode   = LM_BETWEEN;
        if (lx_tokens >= TOKEN_SLOTS - 1) begin
            lx_mode = LM_IGNORE;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void open_operator(logic [7:0] c);
        if (!take_char(c))
            return;
        lx_mode = (c == CH_GT) ? LM_GT : (c == CH_PIPE) ? LM_PIPE : LM_OPDONE;
    endfunction

    function automatic void word_byte(logic [7:0] c);
        case (c)
            CH_SPACE: void'(close_token());
            CH_GT, CH_LT, CH_PIPE: begin
                if (lx_chars == 0 || close_token())
                    open_operator(c);
            end
            CH_SQUOTE: lx_mode = LM_SQ;
            CH_DQUOTE: lx_mode = LM_DQ;
            CH_BSLASH: lx_mode = LM_ESC;
            default:   void'(take_char(c));
        endcase
    endfunction

    function automatic void gap_byte(logic [7:0] c);
        if (c == CH_SPACE)
            return;
        lx_mode = LM_WORD;
        word_byte(c);
    endfunction

    // Works out the results of one accepted transfer into step_res
    function automatic void predict_step(lex_in_t it);
        logic [7:0] c;
        logic [7:0] op;
        c = it.ch;
        step_res.delete();
        if (it.line_end) begin
            case (lx_mode)
                LM_SQ, LM_DQ, LM_DQESC: lx_err = ST_UNMATCHED;
                LM_WORD, LM_ESC, LM_GT, LM_PIPE, LM_OPDONE: void'(close_token());
                default: ;
            endcase
            put_res(KIND_LINE_DONE, 8'h00, TT_WORD, lx_err);
            lex_restart();
        end else begin
            case (lx_mode)
                LM_BETWEEN: gap_byte(c);
                LM_WORD:    word_byte(c);
                LM_SQ: begin
                    if (c == CH_SQUOTE)
                        lx_mode = LM_WORD;
                    else
                        void'(take_char(c));
                end
                LM_DQ: begin
                    if (c == CH_DQUOTE)
                        lx_mode = LM_WORD;
                    else if (c == CH_BSLASH)
                        lx_mode = LM_DQESC;
                    else
                        void'(take_char(c));
                end
                LM_ESC: begin
                    lx_mode = LM_WORD;
                    void'(take_char(c));
                end
                LM_DQESC: begin
                    // only four characters escape inside double quotes
                    lx_mode = LM_DQ;
                    if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BTICK)
                        void'(take_char(c));
                    else if (take_char(CH_BSLASH))
                        void'(take_char(c));
                end
                LM_GT, LM_PIPE: begin
                    op = (lx_mode == LM_GT) ? CH_GT : CH_PIPE;
                    if (c == op) begin
                        if (take_char(c))
                            void'(close_token());
                    end else if (close_token()) begin
                        gap_byte(c);
                    end
                end
                LM_OPDONE: begin
                    if (close_token())
                        gap_byte(c);
                end
                default: ;
            endcase
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Random line building
    // ---------------------------------------------------------------
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH ||
               b == CH_LT || b == CH_GT || b == CH_PIPE);
        return b;
    endfunction

    // One character of double-quoted text, escapes included
    function automatic void push_dq_char();
        logic [7:0] b;
        int         pick;
        if ($urandom_range(0, 3) == 0) begin
            line_q.push_back(CH_BSLASH);
            pick = $urandom_range(0, 4);
            case (pick)
                0:       line_q.push_back(CH_DQUOTE);
                1:       line_q.push_back(CH_BSLASH);
                2:       line_q.push_back(CH_DOLLAR);
                3:       line_q.push_back(CH_BTICK);
                default: line_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end else begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_DQUOTE || b == CH_BSLASH);
            line_q.push_back(b);
        end
    endfunction

    function automatic void push_sq_text(int len);
        logic [7:0] b;
        repeat (len) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_SQUOTE);
            line_q.push_back(b);
        end
    endfunction

    function automatic void push_token();
        int sel;
        int len;
        sel = $urandom_range(0, 10);
        len = $urandom_range(0, 5);
        case (sel)
            0, 1, 2: repeat (len + 1) line_q.push_back(plain_byte());
            3: begin
                line_q.push_back(CH_SQUOTE);
                push_sq_text(len);
                line_q.push_back(CH_SQUOTE);
            end
            4: begin
                line_q.push_back(CH_DQUOTE);
                repeat (len) push_dq_char();
                line_q.push_back(CH_DQUOTE);
            end
            5: begin
                line_q.push_back(CH_BSLASH);
                line_q.push_back(8'($urandom_range(0, 255)));
            end
            6: line_q.push_back(CH_GT);
            7: begin
                line_q.push_back(CH_GT);
                line_q.push_back(CH_GT);
            end
            8: line_q.push_back(CH_LT);
            9: line_q.push_back(CH_PIPE);
            default: begin
                line_q.push_back(CH_PIPE);
                line_q.push_back(CH_PIPE);
            end
        endcase
    endfunction

    // Zero spaces lets neighbouring tokens run together
    function automatic void push_gap();
        repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2))
            line_q.push_back(CH_SPACE);
    endfunction

    function automatic void build_line();
        int shape;
        shape = $urandom_range(0, 99);
        line_q.delete();
        if (shape < 84) begin
            // well-formed line of mixed tokens
            repeat ($urandom_range(0, 8)) begin
                push_token();
                push_gap();
            end
        end else if (shape < 92) begin
            repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(0, 255)));
        end else if (shape < 97) begin
            // broken endings: open quotes, dangling escapes, or a trailing >
            repeat ($urandom_range(0, 3)) begin
                push_token();
                push_gap();
            end
            case ($urandom_range(0, 4))
                0: begin
                    line_q.push_back(CH_SQUOTE);
                    push_sq_text($urandom_range(0, 3));
                end
                1: begin
                    line_q.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) push_dq_char();
                end
                2: begin
                    line_q.push_back(CH_DQUOTE);
                    repeat ($urandom_range(0, 3)) push_dq_char();
                    line_q.push_back(CH_BSLASH);
                end
                3: line_q.push_back(CH_BSLASH);
                default: line_q.push_back(CH_GT);
            endcase
        end else if (shape < 99) begin
            // runs up to and past the token limit
            repeat ($urandom_range(60, 68)) begin
                push_token();
                line_q.push_back(CH_SPACE);
            end
        end else begin
            // long token with escaped quoted text around the length boundary
            repeat ($urandom_range(248, 256)) line_q.push_back(plain_byte());
            line_q.push_back(CH_DQUOTE);
            repeat (4) push_dq_char();
            line_q.push_back(CH_DQUOTE);
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------
    task automatic send_item(input lex_in_t it, input bit typed, input lex_res_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        // transfer taken at this edge
        sent_items++;
        predict_step(it);
        if (typed)
            want_q.push_back(want);
        else
            foreach (step_res[j])
                want_q.push_back(step_res[j]);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (want_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Output side: ready pattern, long hold-off and checking
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic void cmp_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        lex_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, m_data);
            end else begin
                want = want_q.pop_front();
                cmp_field("kind",        32'(want.kind),        32'(m_data.kind));
                cmp_field("out_char",    32'(want.out_char),    32'(m_data.out_char));
                cmp_field("tok_class",   32'(want.tok_class),   32'(m_data.tok_class));
                cmp_field("status",      32'(want.status),      32'(m_data.status));
                cmp_field("token_count", 32'(want.token_count), 32'(m_data.token_count));
                cmp_field("last",        32'(want.last),        32'(m_data.last));
            end
        end
    end

    always @(posedge aclk) begin
        cyc_count++;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("tb_shell_command_line_lexer_unit: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        lex_in_t     it;
        int          n;
        int          phase;
        int unsigned rand_goal;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        mismatches  = 0;
        cyc_count   = 0;
        sent_items  = 0;
        rx_hold     = 0;
        tx_idle_pct = 31;
        rx_idle_pct = 59;
        lex_restart();

        drill_tab = '{
            // empty line straight after reset
            '{"", 8'h00, 0, 1'b1, 1'b1,
              '{KIND_LINE_DONE, 8'h00, TT_WORD, ST_OK, 6'd0, 1'b1}},
            '{"a", 8'h00, 0, 1'b0, 1'b1,
              '{KIND_CHAR, 8'h61, TT_WORD, ST_OK, 6'd0, 1'b1}},
            // every operator but a lone >, splitting words
            '{">>b<c||d|e", 8'h00, 0, 1'b0, 1'b0, '0},
            '{"", 8'h00, 1, 1'b0, 1'b0, '0},
            '{"", 8'hFF, 1, 1'b1, 1'b0, '0},
            // quoted operator, empty quotes, escaped space
            '{"'>' \"\" x\\ y", 8'h00, 0, 1'b1, 1'b0, '0},
            // double-quote escapes, then a trailing backslash on a word
            '{"\"a\\\"b\\\\c\\$d\\`e\\qf\" z\\", 8'h00, 0, 1'b1, 1'b0, '0},
            // token of a lone trailing backslash
            '{"q \\", 8'h00, 0, 1'b1, 1'b0, '0},
            '{"'open", 8'h00, 0, 1'b1, 1'b1,
              '{KIND_LINE_DONE, 8'h00, TT_WORD, ST_UNMATCHED, 6'd0, 1'b1}},
            '{"\"ab\\", 8'h00, 0, 1'b1, 1'b1,
              '{KIND_LINE_DONE, 8'h00, TT_WORD, ST_UNMATCHED, 6'd0, 1'b1}},
            // one character over the token length
            '{"", 8'h6B, 256, 1'b1, 1'b1,
              '{KIND_LINE_DONE, 8'h00, TT_WORD, ST_TOO_LONG, 6'd0, 1'b1}},
            // token limit reached, remainder dropped silently
            '{"", CH_LT, 70, 1'b1, 1'b1,
              '{KIND_LINE_DONE, 8'h00, TT_WORD, ST_OK, 6'd63, 1'b1}},
            '{"|x < >", 8'h00, 0, 1'b1, 1'b0, '0}
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (drill_tab[i]) begin
            n = drill_tab[i].text.len() + drill_tab[i].reps + int'(drill_tab[i].eol);
            for (int k = 0; k < n; k++) begin
                it.line_end = drill_tab[i].eol && (k == n - 1);
                if (it.line_end)
                    it.ch = 8'($urandom_range(0, 255));
                else if (k < drill_tab[i].text.len())
                    it.ch = drill_tab[i].text[k];
                else
                    it.ch = drill_tab[i].fill;
                send_item(it, drill_tab[i].typed && (k == n - 1), drill_tab[i].want);
            end
        end

        // random lines in three idling phases, topping the run up to the item target
        rand_goal  = ITEM_TARGET - sent_items;
        sent_items = 0;
        phase      = 1;
        while (sent_items < rand_goal) begin
            if (phase == 1 && sent_items >= rand_goal / 3) begin
                drain_results();
                tx_idle_pct = 59;
                rx_idle_pct = 31;
                phase       = 2;
            end else if (phase == 2 && sent_items >= 2 * rand_goal / 3) begin
                drain_results();
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                // long receiver stall with the sender still pushing: fills the queue
                rx_hold     = 300;
                phase       = 3;
            end
            build_line();
            foreach (line_q[j]) begin
                it.ch       = line_q[j];
                it.line_end = 1'b0;
                send_item(it, 1'b0, '0);
            end
            it.ch       = 8'($urandom_range(0, 255));
            it.line_end = 1'b1;
            send_item(it, 1'b0, '0);
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_shell_command_line_lexer_unit: PASS");
        else
            $display("tb_shell_command_line_lexer_unit: FAIL");
        $finish;
    end

endmodule

// File: shell_command_line_lexer_unit.f
src/sclx_pkg.sv
src/shell_command_line_lexer_unit.sv
sim/tb_shell_command_line_lexer_unit.sv
